// ===== rtl/core/lgr_pkg.sv =====
// Shared types and constants for the Life generation row stencil.
package lgr_pkg;

    localparam int unsigned LGR_WORD_W = 64;
    localparam int unsigned LGR_ROWS_W = 16;
    localparam int unsigned LGR_COLS_W = 7;
    localparam int unsigned LGR_ADDR_W = 3;
    localparam int unsigned LGR_DATA_W = 32;

    // Output queue: two entries can enter per word, so keep four.
    localparam int unsigned LGR_Q_DEPTH = 4;
    localparam int unsigned LGR_Q_PTR_W = 2;
    localparam int unsigned LGR_Q_CNT_W = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam logic [LGR_ROWS_W-1:0] NUM_ROWS_RESET = 16'd64;
    localparam logic [LGR_COLS_W-1:0] NUM_COLS_RESET = 7'd64;

    // Life rule constants (B3/S23).
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [LGR_WORD_W-1:0] next_row;
        logic [LGR_ROWS_W-1:0] row_number;
        logic                  frame_done;
    } t_result;

endpackage

// ===== rtl/core/lgr_lane.sv =====
// One column of the Life rule: 3x3 neighborhood in, next cell state out.
module lgr_lane
    import lgr_pkg::*;
(
    input  logic [2:0] i_up,
    input  logic [2:0] i_mid,
    input  logic [2:0] i_down,
    output logic       o_alive
);

    logic [3:0] count;

    // Bit 0 is the column to the left, bit 2 the column to the right.
    assign count = 4'(i_up[0]) + 4'(i_up[1]) + 4'(i_up[2])
                 + 4'(i_mid[0]) + 4'(i_mid[2])
                 + 4'(i_down[0]) + 4'(i_down[1]) + 4'(i_down[2]);

    assign o_alive = (count == BIRTH_COUNT) || (i_mid[1] && (count == SURVIVE_COUNT));

endmodule

// ===== rtl/core/lgr_stencil.sv =====
// Row of Life lanes with dead borders and the merge that masks the active width.
module lgr_stencil
    import lgr_pkg::*;
#(
    parameter int unsigned ROW_WIDTH = 64
) (
    input  logic [ROW_WIDTH-1:0] i_up,
    input  logic [ROW_WIDTH-1:0] i_mid,
    input  logic [ROW_WIDTH-1:0] i_down,
    input  logic [ROW_WIDTH-1:0] i_mask,
    output logic [ROW_WIDTH-1:0] o_next
);

    logic [ROW_WIDTH+1:0] up_pad;
    logic [ROW_WIDTH+1:0] mid_pad;
    logic [ROW_WIDTH+1:0] down_pad;
    logic [ROW_WIDTH-1:0] lane_alive;

    // Drop columns beyond the active width, then pad a dead cell on each side of the row.
    assign up_pad   = {1'b0, i_up & i_mask,   1'b0};
    assign mid_pad  = {1'b0, i_mid & i_mask,  1'b0};
    assign down_pad = {1'b0, i_down & i_mask, 1'b0};

    for (genvar c = 0; c < ROW_WIDTH; c++) begin : g_lane
        lgr_lane u_lane (
            .i_up    (up_pad[c+2:c]),
            .i_mid   (mid_pad[c+2:c]),
            .i_down  (down_pad[c+2:c]),
            .o_alive (lane_alive[c])
        );
    end

    assign o_next = lane_alive & i_mask;

endmodule

// ===== rtl/core/life_generation_row_stencil.sv =====
// Top level: row line registers, two lane stencils, output queue and config port.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_cell_row
//  out     | output    | o_out_valid / i_out_ready| o_next_row, o_row_number, o_frame_done
//  cfg     | input     | psel, penable, pready    | paddr, pwdata, pwrite, prdata
//
// One row word is taken per cycle while o_in_ready is high; both stencils evaluate the word
// in the cycle it is taken. A row gives its result when the next word is taken; the last
// word of a frame also gives its own row's result, so it can queue two. Results pass through
// a four-entry queue, and o_in_ready drops only while it holds more than two results.
// Reset (synchronous, i_rst_n low) clears the row registers, row counter and queue.
module life_generation_row_stencil
    import lgr_pkg::*;
#(
    parameter int unsigned ROW_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [LGR_WORD_W-1:0] i_cell_row,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LGR_WORD_W-1:0] o_next_row,
    output logic [LGR_ROWS_W-1:0] o_row_number,
    output logic                  o_frame_done,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LGR_ADDR_W-1:0] paddr,
    input  logic [LGR_DATA_W-1:0] pwdata,
    output logic [LGR_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    logic [LGR_ROWS_W-1:0] r_num_rows;
    logic [LGR_COLS_W-1:0] r_num_cols;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= NUM_ROWS_RESET;
            r_num_cols <= NUM_COLS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_NUM_ROWS: r_num_rows <= pwdata[LGR_ROWS_W-1:0];
                REG_NUM_COLS: r_num_cols <= pwdata[LGR_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NUM_ROWS: prdata = LGR_DATA_W'(r_num_rows);
            REG_NUM_COLS: prdata = LGR_DATA_W'(r_num_cols);
            default:      prdata = '0;
        endcase
    end

    // Active width mask
    logic [LGR_COLS_W-1:0] width_act;
    logic [LGR_WORD_W-1:0] mask_word;
    logic [ROW_WIDTH-1:0]  mask;

    assign width_act = (r_num_cols > LGR_COLS_W'(ROW_WIDTH)) ? LGR_COLS_W'(ROW_WIDTH)
                                                             : r_num_cols;

    always_comb begin
        for (int i = 0; i < LGR_WORD_W; i++) begin
            mask_word[i] = (LGR_COLS_W'(i) < width_act);
        end
    end

    assign mask = mask_word[ROW_WIDTH-1:0];

    // Row line registers
    logic [ROW_WIDTH-1:0]  r_row_above, n_row_above;
    logic [ROW_WIDTH-1:0]  r_row_middle, n_row_middle;
    logic [LGR_ROWS_W-1:0] r_row_counter, n_row_counter;
    logic [ROW_WIDTH-1:0]  row_in;
    logic [LGR_ROWS_W-1:0] last_row;
    logic                  in_accept;
    logic                  emit_main;
    logic                  emit_flush;
    logic [ROW_WIDTH-1:0]  flush_up;
    logic [ROW_WIDTH-1:0]  main_next;
    logic [ROW_WIDTH-1:0]  flush_next;

    assign in_accept  = i_in_valid && o_in_ready;
    assign row_in     = i_cell_row[ROW_WIDTH-1:0] & mask;
    assign last_row   = (r_num_rows > LGR_ROWS_W'(1)) ? r_num_rows - LGR_ROWS_W'(1) : '0;
    assign emit_main  = (r_row_counter != '0);
    assign emit_flush = (r_row_counter >= last_row);
    // The flush row sees the rows as they stand after this word shifts in.
    assign flush_up   = emit_main ? r_row_middle : '0;

    lgr_stencil #(.ROW_WIDTH(ROW_WIDTH)) u_main (
        .i_up   (r_row_above),
        .i_mid  (r_row_middle),
        .i_down (row_in),
        .i_mask (mask),
        .o_next (main_next)
    );

    lgr_stencil #(.ROW_WIDTH(ROW_WIDTH)) u_flush (
        .i_up   (flush_up),
        .i_mid  (row_in),
        .i_down ('0),
        .i_mask (mask),
        .o_next (flush_next)
    );

    always_comb begin
        n_row_above   = r_row_above;
        n_row_middle  = r_row_middle;
        n_row_counter = r_row_counter;
        if (in_accept) begin
            if (emit_flush) begin
                n_row_above   = '0;
                n_row_middle  = '0;
                n_row_counter = '0;
            end else begin
                n_row_above   = flush_up;
                n_row_middle  = row_in;
                n_row_counter = r_row_counter + LGR_ROWS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_above   <= '0;
            r_row_middle  <= '0;
            r_row_counter <= '0;
        end else begin
            r_row_above   <= n_row_above;
            r_row_middle  <= n_row_middle;
            r_row_counter <= n_row_counter;
        end
    end

    // Output queue
    t_result                q_mem [LGR_Q_DEPTH];
    logic [LGR_Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [LGR_Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [LGR_Q_CNT_W-1:0] r_count, n_count;
    t_result                res_main;
    t_result                res_flush;
    t_result                ent0;
    logic [1:0]             push_n;
    logic                   pop;

    assign res_main.next_row    = LGR_WORD_W'(main_next);
    assign res_main.row_number  = r_row_counter - LGR_ROWS_W'(1);
    assign res_main.frame_done  = 1'b0;
    assign res_flush.next_row   = LGR_WORD_W'(flush_next);
    assign res_flush.row_number = r_row_counter;
    assign res_flush.frame_done = 1'b1;

    assign ent0   = emit_main ? res_main : res_flush;
    assign push_n = in_accept ? (2'(emit_main) + 2'(emit_flush)) : 2'd0;
    assign pop    = o_out_valid && i_out_ready;

    assign n_wr_ptr = r_wr_ptr + LGR_Q_PTR_W'(push_n);
    assign n_rd_ptr = r_rd_ptr + LGR_Q_PTR_W'(pop);
    assign n_count  = r_count + LGR_Q_CNT_W'(push_n) - LGR_Q_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            q_mem[r_wr_ptr] <= ent0;
        end
        if (push_n == 2'd2) begin
            q_mem[r_wr_ptr + LGR_Q_PTR_W'(1)] <= res_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold off input unless two free entries remain.
    assign o_in_ready   = (r_count <= LGR_Q_CNT_W'(LGR_Q_DEPTH - 2));
    assign o_out_valid  = (r_count != '0);
    assign o_next_row   = q_mem[r_rd_ptr].next_row;
    assign o_row_number = q_mem[r_rd_ptr].row_number;
    assign o_frame_done = q_mem[r_rd_ptr].frame_done;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LGR_Q_CNT_W'(LGR_Q_DEPTH))
        else $error("output queue count exceeds depth");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && emit_flush |=> r_row_counter == '0 && r_row_middle == '0
                                    && r_row_above == '0)
        else $error("frame end did not clear row state");

    a_flush_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && emit_flush |=> o_out_valid)
        else $error("frame end result not queued");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && emit_main && emit_flush && !pop |=> r_count == $past(r_count) + 3'd2)
        else $error("last row did not queue two results");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !in_accept |=> r_count == $past(r_count) - 3'd1)
        else $error("queue count wrong after pop");

endmodule

// ===== verif/tb_life_generation_row_stencil.sv =====
// Testbench for the Life row stencil: random rows, scoreboard and APB register writes.
module tb_life_generation_row_stencil;
    timeunit 1ns;
    timeprecision 1ps;
    import lgr_pkg::*;

    typedef struct {
        logic [LGR_WORD_W-1:0] bits;
        bit                    hold_for_drain;
    } t_old_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [LGR_WORD_W-1:0] i_cell_row = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [LGR_WORD_W-1:0] o_next_row;
    logic [LGR_ROWS_W-1:0] o_row_number;
    logic                  o_frame_done;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [LGR_ADDR_W-1:0] paddr = '0;
    logic [LGR_DATA_W-1:0] pwdata = '0;
    logic [LGR_DATA_W-1:0] prdata;
    logic                  pready;

    life_generation_row_stencil u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cell_row   (i_cell_row),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_next_row   (o_next_row),
        .o_row_number (o_row_number),
        .o_frame_done (o_frame_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: register copies and the two stored rows.
    logic [LGR_ROWS_W-1:0] cfg_rows = NUM_ROWS_RESET;
    logic [LGR_COLS_W-1:0] cfg_cols = NUM_COLS_RESET;
    logic [LGR_WORD_W-1:0] row_above = '0;
    logic [LGR_WORD_W-1:0] row_mid = '0;
    logic [LGR_ROWS_W-1:0] row_idx = '0;

    t_old_row    old_rows_q[$];
    t_result     next_gen_rows[$];
    int unsigned error_count = 0;

    // Handshake flags passed from the sampling edge to the driving edge.
    bit          word_taken = 1'b0;
    bit          result_taken = 1'b0;
    bit          word_pending = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    function automatic logic [LGR_WORD_W-1:0] width_mask(logic [LGR_COLS_W-1:0] cols);
        int unsigned w;
        w = (cols > LGR_WORD_W) ? LGR_WORD_W : cols;
        if (w >= LGR_WORD_W) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic int unsigned cell_at(logic [LGR_WORD_W-1:0] row, int c);
        if (c < 0 || c >= LGR_WORD_W) return 0;
        return row[c];
    endfunction

    function automatic logic [LGR_WORD_W-1:0] life_row(logic [LGR_WORD_W-1:0] up,
                                                        logic [LGR_WORD_W-1:0] mid,
                                                        logic [LGR_WORD_W-1:0] down,
                                                        logic [LGR_WORD_W-1:0] mask);
        logic [LGR_WORD_W-1:0] res;
        int unsigned           n;
        res = '0;
        up &= mask;
        mid &= mask;
        down &= mask;
        for (int c = 0; c < LGR_WORD_W; c++) begin
            n = 0;
            for (int d = -1; d <= 1; d++) begin
                n += cell_at(up, c + d) + cell_at(down, c + d);
                if (d != 0) n += cell_at(mid, c + d);
            end
            if (n == BIRTH_COUNT || (mid[c] && n == SURVIVE_COUNT)) res[c] = 1'b1;
        end
        return res & mask;
    endfunction

    // Advance the predictor by one accepted word and queue the rows it completes.
    task automatic step_generation(input logic [LGR_WORD_W-1:0] raw);
        logic [LGR_WORD_W-1:0] mask;
        logic [LGR_WORD_W-1:0] row;
        logic [LGR_ROWS_W-1:0] last;
        mask = width_mask(cfg_cols);
        row = raw & mask;
        last = (cfg_rows > 1) ? cfg_rows - 16'd1 : '0;
        if (row_idx == 0) begin
            row_above = '0;
            row_mid = row;
        end else begin
            next_gen_rows.push_back('{life_row(row_above, row_mid, row, mask),
                                      row_idx - 16'd1, 1'b0});
            row_above = row_mid;
            row_mid = row;
        end
        if (row_idx >= last) begin
            next_gen_rows.push_back('{life_row(row_above, row_mid, '0, mask), row_idx, 1'b1});
            row_idx = '0;
            row_above = '0;
            row_mid = '0;
        end else begin
            row_idx = row_idx + 16'd1;
        end
    endtask

    // Sample both channels.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                result_taken = 1'b1;
                if (next_gen_rows.size() == 0) begin
                    $error("unexpected row: next_row %h row_number %0d frame_done %0d",
                           o_next_row, o_row_number, o_frame_done);
                    error_count++;
                end else begin
                    want = next_gen_rows.pop_front();
                    if (o_next_row !== want.next_row) begin
                        $error("next_row expected %h actual %h", want.next_row, o_next_row);
                        error_count++;
                    end
                    if (o_row_number !== want.row_number) begin
                        $error("row_number expected %0d actual %0d",
                               want.row_number, o_row_number);
                        error_count++;
                    end
                    if (o_frame_done !== want.frame_done) begin
                        $error("frame_done expected %0d actual %0d",
                               want.frame_done, o_frame_done);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                step_generation(i_cell_row);
                word_taken = 1'b1;
            end
        end
    end

    // Sender: hold each word until taken, then wait a random gap.
    always @(negedge i_clk) begin
        t_old_row item;
        if (word_taken) begin
            word_taken = 1'b0;
            word_pending = 1'b0;
            send_gap = send_calm ? 0 : $urandom_range(0, 19);
        end
        if (!word_pending && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (old_rows_q.size() != 0 &&
                         !(old_rows_q[0].hold_for_drain && next_gen_rows.size() != 0)) begin
                item = old_rows_q.pop_front();
                i_cell_row <= item.bits;
                word_pending = 1'b1;
            end
        end
        i_in_valid <= word_pending;
    end

    // Receiver: drop i_out_ready for a random stall after each result.
    always @(negedge i_clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            recv_stall = recv_calm ? 0 : $urandom_range(0, 19);
        end
        if (recv_stall > 0) begin
            recv_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic idx, input logic [LGR_DATA_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_NUM_ROWS) cfg_rows = value[LGR_ROWS_W-1:0];
        else cfg_cols = value[LGR_COLS_W-1:0];
    endtask

    task automatic queue_row(input logic [LGR_WORD_W-1:0] bits, input bit drain = 1'b0);
        old_rows_q.push_back('{bits, drain});
    endtask

    // Wait until every word is taken and every expected row has come out.
    task automatic settle();
        int unsigned waited;
        waited = 0;
        while (old_rows_q.size() != 0 || word_pending) @(posedge i_clk);
        while (next_gen_rows.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        if (next_gen_rows.size() != 0) begin
            $error("%0d expected rows never came out", next_gen_rows.size());
            error_count++;
            next_gen_rows.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [LGR_WORD_W-1:0] random_row();
        logic [LGR_WORD_W-1:0] a;
        logic [LGR_WORD_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return a & b & {$urandom, $urandom};
            1: return a | b;
            2: return '0;
            3: return '1;
            4: return 64'd1 << $urandom_range(0, 63);
            default: return a;
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned rows;
        int unsigned cols;
        int unsigned burst;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset settings; leave the frame open, then shrink it so the next word closes it.
        queue_row('1);
        queue_row('0);
        queue_row(64'hAAAA_AAAA_AAAA_AAAA);
        settle();
        write_reg(REG_NUM_ROWS, 32'd3);
        queue_row(64'h5555_5555_5555_5555);
        settle();

        // Blinker, then the edge columns.
        queue_row('0);
        queue_row(64'h0000_0000_0000_0E00);
        queue_row('0);
        queue_row(64'h8000_0000_0000_0001);
        queue_row(64'hC000_0000_0000_0003);
        queue_row(64'h8000_0000_0000_0001);
        settle();

        // One-row grids.
        write_reg(REG_NUM_ROWS, 32'd1);
        queue_row('1);
        queue_row(64'h8000_0000_0000_0001);
        settle();
        write_reg(REG_NUM_ROWS, 32'hFFFF_0000);
        queue_row(64'h7);
        settle();

        // Zero, saturated and single-column widths.
        write_reg(REG_NUM_ROWS, 32'd2);
        write_reg(REG_NUM_COLS, 32'd0);
        queue_row('1);
        queue_row('1);
        settle();
        write_reg(REG_NUM_COLS, 32'd127);
        queue_row(random_row());
        queue_row(random_row());
        settle();
        write_reg(REG_NUM_COLS, 32'hFFFF_FF81);
        queue_row('1);
        queue_row('1);
        settle();

        // Tallest grid, cut short mid frame.
        write_reg(REG_NUM_ROWS, 32'd65535);
        write_reg(REG_NUM_COLS, 32'd63);
        for (int k = 0; k < 4; k++) queue_row('1);
        settle();
        write_reg(REG_NUM_ROWS, 32'd2);
        queue_row('1, 1'b1);
        settle();

        // Random chunks, each under fresh settings.
        sent = 0;
        while (sent < 500) begin
            case ($urandom_range(0, 9))
                0: rows = 0;
                1: rows = 1;
                2: rows = 2;
                3: rows = 3;
                8: rows = 64;
                9: rows = $urandom_range(13, 40);
                default: rows = $urandom_range(4, 12);
            endcase
            if ($urandom_range(0, 19) == 0) rows = 65535;
            case ($urandom_range(0, 7))
                0: cols = 0;
                1: cols = 1;
                2: cols = 64;
                3: cols = 127;
                4: cols = 63;
                default: cols = $urandom_range(2, 127);
            endcase
            write_reg(REG_NUM_ROWS, {16'($urandom_range(0, 65535)), rows[15:0]});
            write_reg(REG_NUM_COLS, {16'($urandom_range(0, 65535)), 9'd0, cols[6:0]});
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(1, 3) * ((rows == 0) ? 1 : rows) + $urandom_range(0, 3);
            if (burst > 60) burst = 60;
            for (int k = 0; k < burst; k++) queue_row(random_row(), $urandom_range(0, 39) == 0);
            sent += burst;
            settle();
        end

        if (error_count == 0) begin
            $display("[life_generation_row_stencil] OK");
        end else begin
            $display("[life_generation_row_stencil] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[life_generation_row_stencil] ERROR");
        $finish;
    end

endmodule
